// ===== hw/rtl/adr_pkg.sv =====
// Shared types, constants and register map of the affine disk rasterizer.
package adr_pkg;

    // Fixed widths of the register and channel fields.
    localparam int REG_W       = 32;
    localparam int RADIUS_W    = 63;
    localparam int PIXEL_W     = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;

    // A coordinate plus a step, wide enough for any coordinate width up to REG_W.
    localparam int ACC_SUM_W   = REG_W + 1;
    // Width at which the squared distance and the squared radius are compared.
    localparam int DIST_CMP_W  = 64;

    // Defaults for the top-level parameters.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Reset values of the steps: one pixel is 1.0 in Q16.16.
    localparam logic [REG_W-1:0] COL_STEP_X_RST = 32'h0001_0000;
    localparam logic [REG_W-1:0] ROW_STEP_Y_RST = 32'h0001_0000;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ORIGIN_X       = 4'd0,
        REG_ORIGIN_Y       = 4'd1,
        REG_COL_STEP_X     = 4'd2,
        REG_COL_STEP_Y     = 4'd3,
        REG_ROW_STEP_X     = 4'd4,
        REG_ROW_STEP_Y     = 4'd5,
        REG_RADIUS_SQUARED = 4'd6,
        REG_INSIDE_VALUE   = 4'd7
    } reg_index_t;

    // Register file contents as seen by the front and back parts.
    typedef struct packed {
        logic [REG_W-1:0]    origin_x;
        logic [REG_W-1:0]    origin_y;
        logic [REG_W-1:0]    col_step_x;
        logic [REG_W-1:0]    col_step_y;
        logic [REG_W-1:0]    row_step_x;
        logic [REG_W-1:0]    row_step_y;
        logic [RADIUS_W-1:0] radius_squared;
        logic [PIXEL_W-1:0]  inside_value;
    } cfg_regs_t;

    // Scan phase within one row.
    typedef enum logic [1:0] {
        PH_BEFORE = 2'd0,
        PH_INSIDE = 2'd1,
        PH_AFTER  = 2'd2
    } phase_t;

    // Control flags that travel with a pixel through the back pipeline.
    typedef struct packed {
        logic valid;
        logic restart;
        logic sat;
    } stage_flags_t;

endpackage

// ===== hw/rtl/adr_if.sv =====
// Channel interfaces of the affine disk rasterizer: pixel slots, pixels, configuration.

interface adr_pix_in_if;
    logic valid;
    logic ready;
    logic frame_start;
    logic row_begin;

    modport source (output valid, output frame_start, output row_begin, input ready);
    modport sink (input valid, input frame_start, input row_begin, output ready);
endinterface

interface adr_pix_out_if;
    import adr_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_value;
    logic               is_inside;
    logic               coord_saturated;

    modport source (output valid, output pixel_value, output is_inside,
                    output coord_saturated, input ready);
    modport sink (input valid, input pixel_value, input is_inside,
                  input coord_saturated, output ready);
endinterface

interface adr_cfg_if;
    import adr_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/adr_cfg.sv =====
// Configuration register file of the affine disk rasterizer.
module adr_cfg (
    input  logic              clk,
    input  logic              rst_n,
    adr_cfg_if.sink           cfg,
    output adr_pkg::cfg_regs_t cfg_regs
);
    import adr_pkg::*;

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg.ready = 1'b1;
    assign cfg_regs  = regs_reg;

    // Register write decode.
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (reg_index_t'(cfg.index))
                REG_ORIGIN_X:       regs_next.origin_x       = cfg.data[REG_W-1:0];
                REG_ORIGIN_Y:       regs_next.origin_y       = cfg.data[REG_W-1:0];
                REG_COL_STEP_X:     regs_next.col_step_x     = cfg.data[REG_W-1:0];
                REG_COL_STEP_Y:     regs_next.col_step_y     = cfg.data[REG_W-1:0];
                REG_ROW_STEP_X:     regs_next.row_step_x     = cfg.data[REG_W-1:0];
                REG_ROW_STEP_Y:     regs_next.row_step_y     = cfg.data[REG_W-1:0];
                REG_RADIUS_SQUARED: regs_next.radius_squared = cfg.data[RADIUS_W-1:0];
                REG_INSIDE_VALUE:   regs_next.inside_value   = cfg.data[PIXEL_W-1:0];
                default:            regs_next = regs_reg;
            endcase
        end
    end

    // Register storage with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg                <= '0;
            regs_reg.col_step_x     <= COL_STEP_X_RST;
            regs_reg.row_step_y     <= ROW_STEP_Y_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== hw/rtl/adr_front.sv =====
// Front part: accepts pixel slots and steps the saturating coordinate accumulators.
module adr_front #(
    parameter int COORD_WIDTH = adr_pkg::COORD_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    adr_pix_in_if.sink               pix_in,
    input  adr_pkg::cfg_regs_t       cfg_regs,
    input  logic                     queue_full,
    output logic                     push,
    output logic [2*COORD_WIDTH+1:0] entry
);
    import adr_pkg::*;

    localparam int    SUM_W  = ACC_SUM_W;
    localparam longint HI_L  = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam logic signed [SUM_W-1:0] CMAX = SUM_W'(HI_L);
    localparam logic signed [SUM_W-1:0] CMIN = SUM_W'(-HI_L - 1);

    logic signed [COORD_WIDTH-1:0] row_origin_x_reg, row_origin_x_next;
    logic signed [COORD_WIDTH-1:0] row_origin_y_reg, row_origin_y_next;
    logic signed [COORD_WIDTH-1:0] pixel_x_reg, pixel_x_next;
    logic signed [COORD_WIDTH-1:0] pixel_y_reg, pixel_y_next;

    logic                 accept;
    logic                 restart;
    logic                 sat;
    logic [COORD_WIDTH:0] load_x, load_y, row_x, row_y, col_x, col_y;

    // Clamp to the signed coordinate range; the top bit flags a clip.
    function automatic logic [COORD_WIDTH:0] clamp_coord(input logic signed [SUM_W-1:0] v);
        logic [COORD_WIDTH:0] r;
        if (v > CMAX)
            r = {1'b1, COORD_WIDTH'(CMAX)};
        else if (v < CMIN)
            r = {1'b1, COORD_WIDTH'(CMIN)};
        else
            r = {1'b0, COORD_WIDTH'(v)};
        return r;
    endfunction

    assign pix_in.ready = !queue_full;
    assign accept       = pix_in.valid && pix_in.ready;
    assign restart      = pix_in.frame_start || pix_in.row_begin;

    // Candidate coordinates for frame load, row step and column step.
    always_comb
    begin
        load_x = clamp_coord(SUM_W'(signed'(cfg_regs.origin_x)));
        load_y = clamp_coord(SUM_W'(signed'(cfg_regs.origin_y)));
        row_x  = clamp_coord(SUM_W'(row_origin_x_reg) + SUM_W'(signed'(cfg_regs.row_step_x)));
        row_y  = clamp_coord(SUM_W'(row_origin_y_reg) + SUM_W'(signed'(cfg_regs.row_step_y)));
        col_x  = clamp_coord(SUM_W'(pixel_x_reg) + SUM_W'(signed'(cfg_regs.col_step_x)));
        col_y  = clamp_coord(SUM_W'(pixel_y_reg) + SUM_W'(signed'(cfg_regs.col_step_y)));
    end

    // Accumulator update; a frame start wins over a row start.
    always_comb
    begin
        row_origin_x_next = row_origin_x_reg;
        row_origin_y_next = row_origin_y_reg;
        pixel_x_next      = pixel_x_reg;
        pixel_y_next      = pixel_y_reg;
        sat               = 1'b0;
        if (pix_in.frame_start)
        begin
            row_origin_x_next = load_x[COORD_WIDTH-1:0];
            row_origin_y_next = load_y[COORD_WIDTH-1:0];
            pixel_x_next      = load_x[COORD_WIDTH-1:0];
            pixel_y_next      = load_y[COORD_WIDTH-1:0];
            sat               = load_x[COORD_WIDTH] || load_y[COORD_WIDTH];
        end
        else if (pix_in.row_begin)
        begin
            row_origin_x_next = row_x[COORD_WIDTH-1:0];
            row_origin_y_next = row_y[COORD_WIDTH-1:0];
            pixel_x_next      = row_x[COORD_WIDTH-1:0];
            pixel_y_next      = row_y[COORD_WIDTH-1:0];
            sat               = row_x[COORD_WIDTH] || row_y[COORD_WIDTH];
        end
        else
        begin
            pixel_x_next = col_x[COORD_WIDTH-1:0];
            pixel_y_next = col_y[COORD_WIDTH-1:0];
            sat          = col_x[COORD_WIDTH] || col_y[COORD_WIDTH];
        end
    end

    // Each accepted slot pushes its new coordinates into the queue.
    assign push  = accept;
    assign entry = {restart, sat, pixel_x_next, pixel_y_next};

    // Accumulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_origin_x_reg <= '0;
            row_origin_y_reg <= '0;
            pixel_x_reg      <= '0;
            pixel_y_reg      <= '0;
        end
        else if (accept)
        begin
            row_origin_x_reg <= row_origin_x_next;
            row_origin_y_reg <= row_origin_y_next;
            pixel_x_reg      <= pixel_x_next;
            pixel_y_reg      <= pixel_y_next;
        end
    end

endmodule

// ===== hw/rtl/adr_queue.sv =====
// Short first-in first-out queue between the front and back parts.
module adr_queue #(
    parameter int WIDTH = 66,
    parameter int DEPTH = adr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data,
    output logic             full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/adr_back.sv =====
// Back part: squares, distance sum, row phase tracking and the output register.
module adr_back #(
    parameter int COORD_WIDTH = adr_pkg::COORD_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  adr_pkg::cfg_regs_t       cfg_regs,
    input  logic                     head_valid,
    input  logic [2*COORD_WIDTH+1:0] head_data,
    output logic                     pop,
    adr_pix_out_if.source            pix_out
);
    import adr_pkg::*;

    localparam int DIST_W = 2 * COORD_WIDTH;

    logic                    adv;
    logic                    head_restart;
    logic                    head_sat;
    logic [COORD_WIDTH-1:0]  head_x;
    logic [COORD_WIDTH-1:0]  head_y;
    logic [COORD_WIDTH-1:0]  mag_x;
    logic [COORD_WIDTH-1:0]  mag_y;

    stage_flags_t            s1_reg, s2_reg, s3_reg;
    logic [COORD_WIDTH-1:0]  s1_mag_x_reg, s1_mag_y_reg;
    logic [DIST_W-1:0]       s2_sq_x_reg, s2_sq_y_reg;
    logic [DIST_W-1:0]       s3_dist_reg;

    phase_t                  phase_reg, phase_next, phase_start;
    logic                    dist_lt, dist_le;
    logic                    inside_now;
    logic [DIST_CMP_W-1:0]   dist_ext, radius_ext;

    logic                    out_valid_reg;
    logic [PIXEL_W-1:0]      pixel_value_reg;
    logic                    is_inside_reg;
    logic                    coord_sat_reg;

    // The whole pipeline moves when the output slot is free or being taken.
    assign adv = !out_valid_reg || pix_out.ready;
    assign pop = adv && head_valid;

    assign {head_restart, head_sat, head_x, head_y} = head_data;

    // Absolute values; the most negative code maps to its unsigned magnitude.
    assign mag_x = head_x[COORD_WIDTH-1] ? (~head_x + 1'b1) : head_x;
    assign mag_y = head_y[COORD_WIDTH-1] ? (~head_y + 1'b1) : head_y;

    // Pipeline valid and flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg <= '{valid: head_valid, restart: head_restart, sat: head_sat};
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
        end
    end

    // Magnitude, square and sum stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mag_x_reg <= mag_x;
            s1_mag_y_reg <= mag_y;
            s2_sq_x_reg  <= DIST_W'(s1_mag_x_reg) * DIST_W'(s1_mag_x_reg);
            s2_sq_y_reg  <= DIST_W'(s1_mag_y_reg) * DIST_W'(s1_mag_y_reg);
            s3_dist_reg  <= s2_sq_x_reg + s2_sq_y_reg;
        end
    end

    // Distance against the squared radius.
    assign dist_ext    = DIST_CMP_W'(s3_dist_reg);
    assign radius_ext  = DIST_CMP_W'(cfg_regs.radius_squared);
    assign dist_lt     = dist_ext < radius_ext;
    assign dist_le     = dist_ext <= radius_ext;
    assign phase_start = s3_reg.restart ? PH_BEFORE : phase_reg;

    // Next phase; a boundary point moves from before straight to after, skipping inside.
    always_comb
    begin
        unique case (phase_start)
            PH_BEFORE: phase_next = dist_le ? (dist_lt ? PH_INSIDE : PH_AFTER) : PH_BEFORE;
            PH_INSIDE: phase_next = dist_lt ? PH_INSIDE : PH_AFTER;
            PH_AFTER:  phase_next = PH_AFTER;
            default:   phase_next = PH_BEFORE;
        endcase
    end

    // Inside decision for the current pixel.
    always_comb
    begin
        unique case (phase_start)
            PH_BEFORE: inside_now = dist_lt;
            PH_INSIDE: inside_now = dist_lt;
            PH_AFTER:  inside_now = 1'b0;
            default:   inside_now = 1'b0;
        endcase
    end

    // Phase register and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BEFORE;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_reg.valid;
            if (s3_reg.valid)
                phase_reg <= phase_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (adv && s3_reg.valid)
        begin
            pixel_value_reg <= inside_now ? cfg_regs.inside_value : '0;
            is_inside_reg   <= inside_now;
            coord_sat_reg   <= s3_reg.sat;
        end
    end

    assign pix_out.valid           = out_valid_reg;
    assign pix_out.pixel_value     = pixel_value_reg;
    assign pix_out.is_inside       = is_inside_reg;
    assign pix_out.coord_saturated = coord_sat_reg;

endmodule

// ===== hw/rtl/affine_disk_rasterizer.sv =====
// Top level of the affine disk rasterizer: register file, front, queue and back.
//
// Usage: each transfer on pix_in is one pixel slot, flagged frame_start for the
// first pixel of an image and row_begin for the first pixel of a row. Each slot
// yields exactly one transfer on pix_out with the pixel word, an inside flag and
// a flag that a coordinate clipped at its range while forming that pixel.
// Registers are written over cfg (index, data); ready is always high. The user must
// make writes while no pixel is in flight; the block does not enforce this.
// Throughput is one pixel per cycle while pix_out is ready. A pix_in transfer writes
// the queue, then the back part registers magnitude, square, distance sum, and the
// phase compare into the output register, which drives the matching pix_out valid.
// The row phase recurrence closes in the last back stage; the coordinate
// accumulators close in the front.
// Reset (rst_n low, asynchronous) restores the register defaults, clears the
// accumulators and phase, and empties the pipeline and the queue.
// When pix_out stalls, the back pipeline holds and the queue fills; pix_in ready
// drops only when the queue is full.
module affine_disk_rasterizer #(
    parameter int COORD_WIDTH = adr_pkg::COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = adr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    adr_cfg_if.sink       cfg,
    adr_pix_in_if.sink    pix_in,
    adr_pix_out_if.source pix_out
);
    import adr_pkg::*;

    localparam int ENTRY_W = 2 * COORD_WIDTH + 2;

    cfg_regs_t          cfg_regs;
    logic               push;
    logic [ENTRY_W-1:0] entry;
    logic               queue_full;
    logic               pop;
    logic               head_valid;
    logic [ENTRY_W-1:0] head_data;

    // Configuration registers.
    adr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    // Coordinate generation.
    adr_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .cfg_regs   (cfg_regs),
        .queue_full (queue_full),
        .push       (push),
        .entry      (entry)
    );

    // Decoupling queue.
    adr_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .full       (queue_full)
    );

    // Distance test and phase tracking.
    adr_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_regs   (cfg_regs),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .pix_out    (pix_out)
    );

endmodule
